FILE: rtl/nps_pkg.sv
`default_nettype none

package nps_pkg;

    localparam int PATTERN_DEPTH = 256;
    localparam int SAMPLE_RATE   = 44100;
    localparam int REF_RATE      = 44100;
    localparam int ADDR_W        = $clog2(PATTERN_DEPTH);
    localparam int COUNT_W       = ADDR_W + 1;

    localparam logic [1:0] FUNC_TICK   = 2'd0;
    localparam logic [1:0] FUNC_WRITE  = 2'd1;
    localparam logic [1:0] FUNC_REWIND = 2'd2;

    localparam logic [5:0] REST_ID        = 6'd63;
    localparam logic [5:0] NOTE_AMPLITUDE = 6'd48;

    typedef enum logic {
        ST_IDLE,
        ST_EVAL
    } seq_state_t;

    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [15:0]       wr_data;
    } pattern_req_t;

    typedef struct packed {
        logic       active;
        logic [5:0] amplitude;
        logic [8:0] period_total;
        logic       restart_phase;
        logic [7:0] position;
    } seq_result_t;

    typedef logic [6:0] mult_table_t [64];
    typedef logic [8:0] period_table_t [64];

    // Half-period multipliers per note id; the last slot is the rest id and is never used.
    localparam mult_table_t HALF_MULT = '{
        7'd95, 7'd89, 7'd84, 7'd80, 7'd75, 7'd71, 7'd67, 7'd63,
        7'd60, 7'd56, 7'd53, 7'd50, 7'd47, 7'd45, 7'd42, 7'd40,
        7'd38, 7'd35, 7'd33, 7'd32, 7'd30, 7'd28, 7'd27, 7'd25,
        7'd24, 7'd22, 7'd21, 7'd20, 7'd19, 7'd18, 7'd17, 7'd16,
        7'd15, 7'd14, 7'd13, 7'd13, 7'd12, 7'd11, 7'd11, 7'd10,
        7'd9,  7'd9,  7'd8,  7'd8,  7'd7,  7'd7,  7'd7,  7'd6,
        7'd6,  7'd6,  7'd5,  7'd5,  7'd5,  7'd4,  7'd4,  7'd4,
        7'd4,  7'd4,  7'd3,  7'd3,  7'd3,  7'd3,  7'd3,  7'd0
    };

    function automatic period_table_t build_period_table();
        period_table_t tbl;
        int            half;
        for (int i = 0; i < 64; i++) begin
            half   = ((int'(HALF_MULT[i]) * SAMPLE_RATE) / REF_RATE) & 255;
            tbl[i] = 9'(half * 2);
        end
        return tbl;
    endfunction

    localparam period_table_t PERIOD_TABLE = build_period_table();

    function automatic logic [ADDR_W-1:0] to_addr(input logic [7:0] a);
        logic [ADDR_W+7:0] t;
        t = {{ADDR_W{1'b0}}, a};
        return t[ADDR_W-1:0];
    endfunction

    function automatic logic [7:0] to_position(input logic [ADDR_W-1:0] c);
        logic [ADDR_W+7:0] t;
        t = {8'd0, c};
        return t[7:0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/nps_pattern_ram.sv
`default_nettype none

module nps_pattern_ram
    import nps_pkg::*;
(
    input  wire logic         aclk,
    input  wire pattern_req_t req,
    output logic [15:0]       rd_data
);

    logic [15:0] mem [PATTERN_DEPTH];
    logic [15:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: rtl/nps_seq_ctrl.sv
`default_nettype none

module nps_seq_ctrl
    import nps_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        accept,
    input  wire logic [1:0]  func,
    input  wire logic [7:0]  word_addr,
    input  wire logic [15:0] word_data,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_wr_data,
    input  wire logic [15:0] rd_data,
    output pattern_req_t     req,
    output logic             idle,
    output logic             res_valid,
    output seq_result_t      res
);

    seq_state_t         state_reg, state_next;
    logic [ADDR_W-1:0]  cursor_reg, cursor_next;
    logic [COUNT_W-1:0] fetched_reg, fetched_next;
    logic [7:0]         countdown_reg, countdown_next;
    logic               active_reg, active_next;
    logic [5:0]         amp_reg, amp_next;
    logic [8:0]         period_reg, period_next;
    logic               loop_reg;
    logic               restart;
    logic [ADDR_W-1:0]  cursor_inc;
    logic [5:0]         note_id;

    assign cursor_inc = (cursor_reg == ADDR_W'(PATTERN_DEPTH - 1)) ? '0 : cursor_reg + 1'b1;
    assign note_id    = rd_data[7:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cursor_reg    <= '0;
            fetched_reg   <= '0;
            countdown_reg <= '0;
            active_reg    <= 1'b1;
            amp_reg       <= NOTE_AMPLITUDE;
            period_reg    <= '0;
            loop_reg      <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cursor_reg    <= cursor_next;
            fetched_reg   <= fetched_next;
            countdown_reg <= countdown_next;
            active_reg    <= active_next;
            amp_reg       <= amp_next;
            period_reg    <= period_next;
            if (cfg_wr_en) begin
                loop_reg <= cfg_wr_data;
            end
        end
    end

    // Pattern writes are taken only in the idle state, so a read during a fetch
    // never meets a write to the same word.
    always_comb begin
        state_next     = state_reg;
        cursor_next    = cursor_reg;
        fetched_next   = fetched_reg;
        countdown_next = countdown_reg;
        active_next    = active_reg;
        amp_next       = amp_reg;
        period_next    = period_reg;
        restart        = 1'b0;
        res_valid      = 1'b0;
        req            = '0;
        req.wr_addr    = to_addr(word_addr);
        req.wr_data    = word_data;
        req.rd_addr    = cursor_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    res_valid = 1'b1;
                    unique case (func)
                        FUNC_TICK: begin
                            if (active_reg && countdown_reg == 8'd0) begin
                                req.rd_en    = 1'b1;
                                cursor_next  = cursor_inc;
                                fetched_next = COUNT_W'(1);
                                state_next   = ST_EVAL;
                                res_valid    = 1'b0;
                            end else if (active_reg) begin
                                countdown_next = countdown_reg - 8'd1;
                            end
                        end
                        FUNC_WRITE: begin
                            req.wr_en = 1'b1;
                        end
                        FUNC_REWIND: begin
                            cursor_next    = '0;
                            countdown_next = '0;
                            active_next    = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_EVAL: begin
                // An end marker counts only as the first word of a fetch.
                if (fetched_reg == COUNT_W'(1) && rd_data == 16'd0) begin
                    if (loop_reg) begin
                        cursor_next = '0;
                    end else begin
                        active_next = 1'b0;
                    end
                    countdown_next = '0;
                    res_valid      = 1'b1;
                    state_next     = ST_IDLE;
                end else if (rd_data[0]) begin
                    if (fetched_reg >= COUNT_W'(PATTERN_DEPTH)) begin
                        res_valid  = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        req.rd_en    = 1'b1;
                        cursor_next  = cursor_inc;
                        fetched_next = fetched_reg + 1'b1;
                    end
                end else begin
                    if (note_id == REST_ID) begin
                        amp_next = '0;
                    end else begin
                        amp_next    = NOTE_AMPLITUDE;
                        period_next = PERIOD_TABLE[note_id];
                    end
                    countdown_next = rd_data[15:8];
                    restart        = 1'b1;
                    res_valid      = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        res.active        = active_next;
        res.amplitude     = amp_next;
        res.period_total  = period_next;
        res.restart_phase = restart;
        res.position      = to_position(cursor_next);
    end

    assign idle = (state_reg == ST_IDLE);

endmodule

`default_nettype wire

FILE: rtl/note_pattern_sequencer_core.sv
`default_nettype none

// Note pattern sequencer for one square-wave voice.
// Input channel (s_valid/s_ready): func selects a tick, a pattern word write
// (s_word_addr, s_word_data) or a rewind. Every input word yields exactly one
// result word on the m_ channel carrying the voice state after that item.
// loop_enable is written through cfg_wr_en/cfg_wr_data; the user must write it
// only while the block is idle, as the block itself does not enforce this.
// Writes, rewinds and ticks that do not fetch finish in the cycle they are
// accepted, so their result is valid in the cycle after. A tick that fetches
// reads one word of the pattern memory, whose read data is registered, and one
// more for each command word skipped (at most PATTERN_DEPTH reads in total).
// Throughput: one item per cycle for the short items while the receiver keeps up.
// The result sits in an output register; a new item is taken while that
// register is empty or being drained. If the receiver stalls, s_ready drops.
// Reset (aresetn, synchronous): cursor and countdown 0, voice active with
// amplitude 48 and period 0, looping off. Pattern memory is not cleared.
module note_pattern_sequencer_core
    import nps_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_func,
    input  wire logic [7:0]  s_word_addr,
    input  wire logic [15:0] s_word_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_active,
    output logic [5:0]       m_amplitude,
    output logic [8:0]       m_period_total,
    output logic             m_restart_phase,
    output logic [7:0]       m_position,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_wr_data
);

    pattern_req_t ram_req;
    logic [15:0]  ram_rd_data;
    logic         ctrl_idle;
    logic         res_valid;
    seq_result_t  res;
    logic         s_accept;
    logic         m_valid_reg;
    seq_result_t  out_reg;

    assign s_ready  = ctrl_idle && (!m_valid_reg || m_ready);
    assign s_accept = s_valid && s_ready;

    nps_seq_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (s_accept),
        .func        (s_func),
        .word_addr   (s_word_addr),
        .word_data   (s_word_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .rd_data     (ram_rd_data),
        .req         (ram_req),
        .idle        (ctrl_idle),
        .res_valid   (res_valid),
        .res         (res)
    );

    nps_pattern_ram u_ram (
        .aclk    (aclk),
        .req     (ram_req),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            out_reg <= res;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_active        = out_reg.active;
    assign m_amplitude     = out_reg.amplitude;
    assign m_period_total  = out_reg.period_total;
    assign m_restart_phase = out_reg.restart_phase;
    assign m_position      = out_reg.position;

    // A result must never land on a word the receiver has not yet taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> (!m_valid_reg || m_ready))
        else $error("result overwrote a pending output word");

    // While a fetch is in progress the output register stays empty.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !ctrl_idle |-> !m_valid_reg)
        else $error("output word pending during pattern fetch");

    // A fetch finishes with a result, or keeps reading the memory.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (!ctrl_idle && !res_valid) |-> ram_req.rd_en)
        else $error("fetch stalled without a memory read");

    // A note or rest start only happens on an active voice.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res.restart_phase) |-> (res.active && !ctrl_idle))
        else $error("phase restart outside a fetch");

endmodule

`default_nettype wire
